[rtl/msr_pkg.sv]
// Package for the modular square root block.
// Holds field widths, status codes and the transaction payload structs.
// No dependencies.
package msr_pkg;

	localparam int WIDTH        = 30;
	localparam int SEARCH_LIMIT = 65536;

	localparam logic [1:0] STAT_ZERO    = 2'd0;
	localparam logic [1:0] STAT_NO_ROOT = 2'd1;
	localparam logic [1:0] STAT_TWO     = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic [WIDTH-1:0] modulus;
	} msr_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [WIDTH-1:0] root_small;
		logic [WIDTH-1:0] root_large;
	} msr_rsp_t;

endpackage

[rtl/modular_square_root.sv]
// Modular square root by Cipolla's method, top level.
// Depends on msr_pkg (widths, status codes, payload structs).
//
// Usage:
//   Request channel in_valid/in_ready/in_data carries value n and odd prime
//   modulus p. Response channel out_valid/out_ready/out_data carries status
//   and the two roots in ascending order (zero unless status is two roots).
//   One response per request transaction.
// Arithmetic:
//   All multiplications run on one shared modular multiplier: a multiply
//   into a product register, then a restoring reduction that takes one
//   product bit per cycle. Invalid or zero input is answered from the idle
//   state without the multiplier. Otherwise Euler's check costs up to
//   2*WIDTH products, each tried search candidate one product plus another
//   Euler check, and the extension power up to 10*WIDTH products.
// Throughput:
//   One request at a time; in_ready is high only while the sequencer idles.
//   A finished response sits in the output register, so the next request
//   is taken while the receiver stalls; a second response waits in the
//   sequencer until the output register is free.
// Reset:
//   arst_n clears the sequencer and the output valid flag; no response
//   is pending after reset.
module modular_square_root (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msr_pkg::msr_req_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output msr_pkg::msr_rsp_t out_data
);
	import msr_pkg::*;

	localparam int W   = WIDTH;
	localparam int MCW = $clog2(2*W+1);
	localparam int AW  = (W > 17) ? W : 17;

	// sequencer state codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WAIT  = 4'd1;
	localparam logic [3:0] ST_PLOOP = 4'd2;
	localparam logic [3:0] ST_PACC  = 4'd3;
	localparam logic [3:0] ST_PSQ   = 4'd4;
	localparam logic [3:0] ST_PSQN  = 4'd5;
	localparam logic [3:0] ST_PEND  = 4'd6;
	localparam logic [3:0] ST_SA    = 4'd7;
	localparam logic [3:0] ST_SD    = 4'd8;
	localparam logic [3:0] ST_XLOOP = 4'd9;
	localparam logic [3:0] ST_X1    = 4'd10;
	localparam logic [3:0] ST_X2    = 4'd11;
	localparam logic [3:0] ST_X3    = 4'd12;
	localparam logic [3:0] ST_X4    = 4'd13;
	localparam logic [3:0] ST_X5    = 4'd14;
	localparam logic [3:0] ST_X6    = 4'd15;

	logic [3:0]       state_q, nxt_q;
	logic [W-1:0]     p_q, n_q, a_q, d_q, e_q;
	logic [W-1:0]     x_re_q, x_im_q, b_re_q, b_im_q;  // acc / base (scalar uses re)
	logic [W-1:0]     t_q, re_new_q;
	logic             srch_q, xsq_q, done_q;
	logic [1:0]       status_q;
	logic [W-1:0]     rs_q, rl_q;
	logic             out_valid_q;
	msr_rsp_t         out_q;

	// shared modular multiplier
	logic [2*W-1:0]   prod_q;
	logic [W-1:0]     rem_q;
	logic [MCW-1:0]   mcnt_q;
	logic             mbusy_q;
	logic             mstart, mdone;
	logic [W-1:0]     mul_x, mul_y;
	logic [W:0]       red_sh, red_sub;

	function automatic logic [W-1:0] add_mod(input logic [W-1:0] u, input logic [W-1:0] v,
			input logic [W-1:0] m);
		logic [W:0] s;
		logic [W:0] r;
		s = {1'b0, u} + {1'b0, v};
		r = s - {1'b0, m};
		add_mod = (s >= {1'b0, m}) ? r[W-1:0] : s[W-1:0];
	endfunction

	// operand selection for the shared multiplier
	logic [W-1:0] xr, xi;
	assign xr = xsq_q ? b_re_q : x_re_q;
	assign xi = xsq_q ? b_im_q : x_im_q;

	always_comb begin
		mstart = 1'b0;
		mul_x  = '0;
		mul_y  = '0;
		case (state_q)
			ST_PLOOP: begin
				mstart = (e_q != '0) && e_q[0];
				mul_x  = x_re_q;
				mul_y  = b_re_q;
			end
			ST_PSQ: begin
				mstart = 1'b1;
				mul_x  = b_re_q;
				mul_y  = b_re_q;
			end
			ST_SA: begin
				mstart = 1'b1;
				mul_x  = a_q;
				mul_y  = a_q;
			end
			ST_X1: begin
				mstart = 1'b1;
				mul_x  = d_q;
				mul_y  = xi;
			end
			ST_X2: begin
				mstart = 1'b1;
				mul_x  = rem_q;
				mul_y  = b_im_q;
			end
			ST_X3: begin
				mstart = 1'b1;
				mul_x  = xr;
				mul_y  = b_re_q;
			end
			ST_X4: begin
				mstart = 1'b1;
				mul_x  = xr;
				mul_y  = b_im_q;
			end
			ST_X5: begin
				mstart = 1'b1;
				mul_x  = xi;
				mul_y  = b_re_q;
			end
			default: begin
				mstart = 1'b0;
			end
		endcase
	end

	// one restoring reduction step per cycle
	assign red_sh  = {rem_q, prod_q[2*W-1]};
	assign red_sub = red_sh - {1'b0, p_q};
	assign mdone   = mbusy_q && (mcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (mstart) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= MCW'(2*W);
		end else if (mbusy_q && mcnt_q != '0) begin
			mcnt_q <= mcnt_q - MCW'(1);
		end else if (mdone) begin
			mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mstart) begin
			prod_q <= mul_x * mul_y;
			rem_q  <= '0;
		end else if (mbusy_q && mcnt_q != '0) begin
			prod_q <= {prod_q[2*W-2:0], 1'b0};
			rem_q  <= (red_sh >= {1'b0, p_q}) ? red_sub[W-1:0] : red_sh[W-1:0];
		end
	end

	// sequencer
	logic [W:0]   sd_sum, sd_sub;
	logic [W-1:0] r_other;
	assign sd_sum  = {1'b0, rem_q} + {1'b0, p_q} - {1'b0, n_q};
	assign sd_sub  = sd_sum - {1'b0, p_q};
	assign r_other = p_q - x_re_q;

	assign in_ready = (state_q == ST_IDLE) && !done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nxt_q   <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			if (done_q && (!out_valid_q || out_ready)) begin
				done_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.modulus < W'(3) || !in_data.modulus[0] ||
								in_data.value >= in_data.modulus ||
								in_data.value == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_PLOOP;
						end
					end
				end
				ST_WAIT: begin
					if (mdone) begin
						state_q <= nxt_q;
					end
				end
				ST_PLOOP: begin
					if (e_q == '0) begin
						state_q <= ST_PEND;
					end else if (e_q[0]) begin
						state_q <= ST_WAIT;
						nxt_q   <= ST_PACC;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				ST_PACC: state_q <= ST_PSQ;
				ST_PSQ: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_PSQN;
				end
				ST_PSQN: state_q <= ST_PLOOP;
				ST_PEND: begin
					if (!srch_q) begin
						if (x_re_q != W'(1)) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SA;
						end
					end else if (x_re_q != W'(1)) begin
						state_q <= ST_XLOOP;
					end else if (a_q == p_q - W'(1) || AW'(a_q) == AW'(SEARCH_LIMIT)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SA;
					end
				end
				ST_SA: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_SD;
				end
				ST_SD: state_q <= ST_PLOOP;
				ST_XLOOP: begin
					if (e_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_X1;
					end
				end
				ST_X1: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_X2;
				end
				ST_X2: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_X3;
				end
				ST_X3: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_X4;
				end
				ST_X4: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_X5;
				end
				ST_X5: begin
					state_q <= ST_WAIT;
					nxt_q   <= ST_X6;
				end
				ST_X6: state_q <= xsq_q ? ST_XLOOP : ST_X1;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					p_q      <= in_data.modulus;
					n_q      <= in_data.value;
					status_q <= (in_data.modulus < W'(3) || !in_data.modulus[0] ||
							in_data.value >= in_data.modulus) ? STAT_INVALID : STAT_ZERO;
					rs_q     <= '0;
					rl_q     <= '0;
					srch_q   <= 1'b0;
					x_re_q   <= W'(1);
					b_re_q   <= in_data.value;
					e_q      <= in_data.modulus >> 1;
				end
			end
			ST_PACC: x_re_q <= rem_q;
			ST_PSQN: begin
				b_re_q <= rem_q;
				e_q    <= e_q >> 1;
			end
			ST_PEND: begin
				if (!srch_q) begin
					status_q <= STAT_NO_ROOT;
					a_q      <= W'(1);
				end else if (x_re_q != W'(1)) begin
					x_re_q <= W'(1);
					x_im_q <= '0;
					b_re_q <= a_q;
					b_im_q <= W'(1);
					e_q    <= (p_q >> 1) + W'(1);
				end else begin
					a_q <= a_q + W'(1);
				end
			end
			ST_SD: begin
				d_q    <= (sd_sum >= {1'b0, p_q}) ? sd_sub[W-1:0] : sd_sum[W-1:0];
				b_re_q <= (sd_sum >= {1'b0, p_q}) ? sd_sub[W-1:0] : sd_sum[W-1:0];
				x_re_q <= W'(1);
				e_q    <= p_q >> 1;
				srch_q <= 1'b1;
			end
			ST_XLOOP: begin
				if (e_q == '0) begin
					status_q <= STAT_TWO;
					rs_q     <= (x_re_q > r_other) ? r_other : x_re_q;
					rl_q     <= (x_re_q > r_other) ? x_re_q : r_other;
				end
				xsq_q <= !e_q[0];
			end
			ST_X2: t_q <= rem_q;
			ST_X3: t_q <= rem_q;
			ST_X4: re_new_q <= add_mod(rem_q, t_q, p_q);
			ST_X5: t_q <= rem_q;
			ST_X6: begin
				if (xsq_q) begin
					b_re_q <= re_new_q;
					b_im_q <= add_mod(t_q, rem_q, p_q);
					e_q    <= e_q >> 1;
				end else begin
					x_re_q <= re_new_q;
					x_im_q <= add_mod(t_q, rem_q, p_q);
					xsq_q  <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_q && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && (!out_valid_q || out_ready)) begin
			out_q.status     <= status_q;
			out_q.root_small <= rs_q;
			out_q.root_large <= rl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mbusy_q)
		else $error("multiplier busy while sequencer idles");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (rem_q < p_q))
		else $error("reduced product not below modulus");

	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != STAT_TWO) |->
			(out_q.root_small == '0 && out_q.root_large == '0))
		else $error("nonzero root with single or no root status");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_TWO) |-> (out_q.root_small <= out_q.root_large))
		else $error("roots out of order");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mbusy_q |-> !in_ready)
		else $error("request taken while a product is in progress");

endmodule
